FILE: hdl/polar_pose_tracking_controller_macros.svh
// Assertion macros used by the port-level checker.
`ifndef POLAR_POSE_TRACKING_CONTROLLER_MACROS_SVH
`define POLAR_POSE_TRACKING_CONTROLLER_MACROS_SVH
// Implication checked on every clock, off during reset.
`define PPTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked on every clock, off during reset.
`define PPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hdl/pptc_pkg.sv
// Package with formats, constants and command types of the pose tracking controller.
package pptc_pkg;
	localparam int CordicIters = 16;
	localparam int TableLen = 24;
	localparam int IterW = 5;
	localparam logic signed [31:0] PiQ24 = 32'sd52707179;
	localparam logic signed [31:0] TwoPiQ24 = 32'sd105414358;
	localparam logic signed [31:0] HalfPiQ24 = 32'sd26353589;
	localparam logic [15:0] TwoPiQ12 = 16'd25736;
	localparam logic signed [18:0] HalfPiQ12 = 19'sd6434;
	localparam logic signed [31:0] GainQ30 = 32'sd652032874;
	localparam logic [15:0] GainQ16 = 16'd39797;

	localparam logic [2:0] REG_K_RHO = 3'd0;
	localparam logic [2:0] REG_K_ALPHA = 3'd1;
	localparam logic [2:0] REG_K_BETA = 3'd2;
	localparam logic [2:0] REG_RADIUS = 3'd3;
	localparam logic [2:0] REG_STEP = 3'd4;
	localparam logic [2:0] REG_TOL = 3'd5;
	localparam logic [2:0] REG_TURN = 3'd6;
	localparam logic [2:0] REG_SPIN = 3'd7;

	typedef struct packed {
		logic load;      // capture item, set up rotation
		logic rot_step;  // one rotation iteration
		logic goal;      // form goal and differences
		logic vec_init;  // set up vectoring
		logic vec_step;  // one vectoring iteration
		logic mag;       // magnitude multiply
		logic ctl;       // angles and products
		logic fin;       // saturate, commit
	} cmd_t;

	typedef struct packed {
		logic iter_last;
	} status_t;

	function automatic logic signed [31:0] atan_q24(input logic [IterW-1:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0: r = 32'sd13176795;
			5'd1: r = 32'sd7778716;
			5'd2: r = 32'sd4110060;
			5'd3: r = 32'sd2086331;
			5'd4: r = 32'sd1047214;
			5'd5: r = 32'sd524117;
			5'd6: r = 32'sd262123;
			5'd7: r = 32'sd131069;
			default: r = 32'sd65536 >>> (i - 5'd8);
		endcase
		return r;
	endfunction
endpackage

FILE: hdl/pptc_ctrl.sv
// Sequencer for the pose tracking controller.
module pptc_ctrl
	import pptc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT = 3'd1;
	localparam logic [2:0] ST_GOAL = 3'd2;
	localparam logic [2:0] ST_VINIT = 3'd3;
	localparam logic [2:0] ST_VEC = 3'd4;
	localparam logic [2:0] ST_MAG = 3'd5;
	localparam logic [2:0] ST_CTL = 3'd6;
	localparam logic [2:0] ST_FIN = 3'd7;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       fin_ok;

	// The final step may only run once the output register is free.
	assign fin_ok = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.rot_step = (state_q == ST_ROT);
		cmd.goal = (state_q == ST_GOAL);
		cmd.vec_init = (state_q == ST_VINIT);
		cmd.vec_step = (state_q == ST_VEC);
		cmd.mag = (state_q == ST_MAG);
		cmd.ctl = (state_q == ST_CTL);
		cmd.fin = (state_q == ST_FIN) && fin_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && fin_ok) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_ROT;
				ST_ROT: if (status.iter_last) state_q <= ST_GOAL;
				ST_GOAL: state_q <= ST_VINIT;
				ST_VINIT: state_q <= ST_VEC;
				ST_VEC: if (status.iter_last) state_q <= ST_MAG;
				ST_MAG: state_q <= ST_CTL;
				ST_CTL: state_q <= ST_FIN;
				ST_FIN: if (fin_ok) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/pptc_dp.sv
// Datapath: configuration, phase, shared CORDIC and output terms.
module pptc_dp
	import pptc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [14:0] heading,
	input  cmd_t               cmd,
	output status_t            status,
	output logic signed [15:0] lin_speed,
	output logic signed [15:0] ang_rate,
	output logic               spin_override,
	output logic               waypoint_advanced
);
	logic signed [15:0] k_rho_q, k_alpha_q, k_beta_q, spin_rate_q;
	logic [14:0]        radius_q, tol_q;
	logic [13:0]        step_q, turn_q;
	logic [15:0]        phase_q;

	logic signed [15:0] px_q, py_q;
	logic signed [14:0] th_q;
	logic               neg_q, zero_q;
	logic [IterW-1:0]   it_q;
	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic signed [17:0] dx_q, dy_q;
	logic signed [20:0] rho_q;
	logic signed [19:0] alpha_q;
	logic signed [37:0] v_q;
	logic signed [39:0] w_q;
	logic               spin_q, adv_q;
	logic [15:0]        gnext_q;

	// Goal angle and its reduction into the right half plane.
	logic [16:0]        g_sum;
	logic [15:0]        g_w;
	logic signed [31:0] a0, a1, a2;
	logic               neg0;
	always_comb begin
		g_sum = {1'b0, phase_q} + {3'b0, step_q};
		g_w = (g_sum >= {1'b0, TwoPiQ12}) ? 16'(g_sum - {1'b0, TwoPiQ12}) : g_sum[15:0];
		a0 = $signed({4'b0, g_w, 12'b0});
		a1 = (a0 > PiQ24) ? a0 - TwoPiQ24 : a0;
		neg0 = 1'b0;
		a2 = a1;
		if (a1 > HalfPiQ24) begin
			a2 = a1 - PiQ24;
			neg0 = 1'b1;
		end else if (a1 < -HalfPiQ24) begin
			a2 = a1 + PiQ24;
			neg0 = 1'b1;
		end
	end

	// One shared CORDIC stage; the mode follows the command.
	logic signed [33:0] xs, ys, at;
	logic               dir;
	always_comb begin
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		at = 34'(atan_q24(it_q));
		dir = cmd.rot_step ? (z_q >= 0) : (y_q > 0);
	end
	assign status.iter_last = (it_q == IterW'(CordicIters - 1));

	// Goal coordinates after rotation.
	logic signed [33:0] sn, cs;
	logic signed [49:0] pgx, pgy;
	logic signed [17:0] gx, gy, ndx, ndy;
	always_comb begin
		sn = neg_q ? -y_q : y_q;
		cs = neg_q ? -x_q : x_q;
		pgx = $signed({1'b0, radius_q}) * sn;
		pgy = $signed({1'b0, radius_q}) * cs;
		gx = 18'((pgx + (50'sd1 <<< 29)) >>> 30);
		gy = 18'((pgy + (50'sd1 <<< 29)) >>> 30);
		ndx = gx - 18'(px_q);
		ndy = gy - 18'(py_q);
	end

	// Output terms.
	logic signed [51:0] pmag;
	logic signed [20:0] bear12;
	logic signed [19:0] alpha_n;
	logic signed [37:0] vr;
	logic signed [39:0] wr;
	logic signed [15:0] v_sat, w_sat;
	logic [14:0]        th_abs;
	logic [17:0]        adx, ady;
	logic [16:0]        p_sum;
	always_comb begin
		pmag = x_q * $signed({1'b0, GainQ16});
		bear12 = 21'((z_q + 34'sd2048) >>> 12);
		alpha_n = 20'(bear12) - 20'(th_q);
		vr = (v_q + 38'sd128) >>> 8;
		if (!(alpha_q < 20'(HalfPiQ12) && alpha_q > -20'(HalfPiQ12))) vr = -vr;
		wr = (-w_q + 40'sd2048) >>> 12;
		v_sat = (vr > 38'sd32767) ? 16'sh7fff : (vr < -38'sd32768) ? 16'sh8000 : 16'(vr);
		w_sat = (wr > 40'sd32767) ? 16'sh7fff : (wr < -40'sd32768) ? 16'sh8000 : 16'(wr);
		th_abs = th_q[14] ? 15'(-th_q) : 15'(th_q);
		adx = dx_q[17] ? 18'(-dx_q) : 18'(dx_q);
		ady = dy_q[17] ? 18'(-dy_q) : 18'(dy_q);
		p_sum = {1'b0, phase_q} + {3'b0, step_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_rho_q <= 16'sd268;
			k_alpha_q <= 16'sd2304;
			k_beta_q <= -16'sd13;
			radius_q <= 15'd2560;
			step_q <= 14'd2574;
			tol_q <= 15'd77;
			turn_q <= 14'd12493;
			spin_rate_q <= 16'sd256;
			phase_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_K_RHO: k_rho_q <= cfg_data;
					REG_K_ALPHA: k_alpha_q <= cfg_data;
					REG_K_BETA: k_beta_q <= cfg_data;
					REG_RADIUS: radius_q <= cfg_data[14:0];
					REG_STEP: step_q <= cfg_data[13:0];
					REG_TOL: tol_q <= cfg_data[14:0];
					REG_TURN: turn_q <= cfg_data[13:0];
					REG_SPIN: spin_rate_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.fin && adv_q) phase_q <= gnext_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pos_x;
			py_q <= pos_y;
			th_q <= heading;
			neg_q <= neg0;
			x_q <= 34'(GainQ30);
			y_q <= '0;
			z_q <= 34'(a2);
			it_q <= '0;
		end else if (cmd.rot_step || cmd.vec_step) begin
			if (dir ^ cmd.vec_step) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			it_q <= it_q + 1'b1;
		end else if (cmd.goal) begin
			dx_q <= ndx;
			dy_q <= ndy;
		end else if (cmd.vec_init) begin
			it_q <= '0;
			zero_q <= (dx_q == 0) && (dy_q == 0);
			if (dx_q < 0) begin
				x_q <= -(34'(dx_q) <<< 12);
				y_q <= -(34'(dy_q) <<< 12);
				z_q <= (dy_q >= 0) ? 34'(PiQ24) : -34'(PiQ24);
			end else begin
				x_q <= 34'(dx_q) <<< 12;
				y_q <= 34'(dy_q) <<< 12;
				z_q <= '0;
			end
		end else if (cmd.mag) begin
			rho_q <= zero_q ? '0 : 21'((pmag + (52'sd1 <<< 27)) >>> 28);
			alpha_q <= zero_q ? -20'(th_q) : alpha_n;
			adv_q <= (adx < 18'(tol_q)) && (ady < 18'(tol_q));
			spin_q <= (th_abs >= 15'(turn_q));
			gnext_q <= (p_sum >= {1'b0, TwoPiQ12}) ? 16'(p_sum - {1'b0, TwoPiQ12}) :
				p_sum[15:0];
		end else if (cmd.ctl) begin
			v_q <= 38'(k_rho_q * rho_q);
			w_q <= 40'(k_alpha_q * alpha_q) + 40'(k_beta_q * (-20'(th_q) - alpha_q));
		end else if (cmd.fin) begin
			lin_speed <= spin_q ? 16'sd0 : v_sat;
			ang_rate <= spin_q ? spin_rate_q : w_sat;
			spin_override <= spin_q;
			waypoint_advanced <= adv_q;
		end
	end
endmodule

FILE: hdl/polar_pose_tracking_controller.sv
// Top level of the polar pose tracking controller.
//  channel  direction  handshake           payload
//  in       to block   in_valid/in_stall   pos_x, pos_y, heading
//  out      from block out_valid/out_stall lin_speed, ang_rate, spin_override, waypoint_advanced
//  cfg      to block   cfg_we              cfg_index, cfg_data
// Each item passes through the shared CORDIC stage, first in the rotation pass and then
// in the vectoring pass.
// The result register frees the block for the next item while a result waits.
// A stalled output holds the last step until the result register is free.
// Reset loads the register defaults and clears the path phase.
module polar_pose_tracking_controller
	import pptc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [14:0] heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] lin_speed,
	output logic signed [15:0] ang_rate,
	output logic               spin_override,
	output logic               waypoint_advanced,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	cmd_t    cmd;
	status_t status;

	pptc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	pptc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.cmd(cmd), .status(status), .lin_speed(lin_speed), .ang_rate(ang_rate),
		.spin_override(spin_override), .waypoint_advanced(waypoint_advanced)
	);
endmodule

FILE: hdl/pptc_checker.sv
// Port-level checker for the pose tracking controller and its binding.
`include "polar_pose_tracking_controller_macros.svh"
module pptc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] lin_speed,
	input logic               spin_override
);
	`PPTC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(lin_speed), "result dropped or changed while stalled")
	`PPTC_ASSERT_IMP(a_spin_zero, clk, arst_n, out_valid && spin_override, lin_speed == 16'sd0, "spin result with nonzero speed")
	`PPTC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "second item taken while busy")
	`PPTC_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && !in_stall && !out_valid, !out_valid, "result appeared one cycle after accept")
endmodule

bind polar_pose_tracking_controller pptc_checker u_pptc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .lin_speed(lin_speed),
	.spin_override(spin_override)
);
